/* rtl/core/spi_pkg.sv */
// shared constants and types for the stroke point interpolator
// no dependencies; spi_div, spi_back and the top level refer to it by scoped names
package spi_pkg;

    localparam int COORD_BITS_DEFAULT  = 12;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int STEPS_BITS   = 6;
    localparam int HEIGHT_BITS  = 11;
    localparam int STEPS_RESET  = 30;
    localparam int STEPS_LIMIT  = 32;
    localparam int HEIGHT_RESET = 480;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 11;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_STEPS     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CANVAS_HEIGHT = 2'd1;

    // handshake between the sequencer and the shared divider
    typedef struct packed {
        logic busy;
        logic done;
    } spi_div_status_t;

endpackage

/* rtl/core/spi_div.sv */
// iterative restoring divider, one quotient bit per cycle
// depends on spi_pkg for the status struct
module spi_div #(
    parameter int W = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [W-1:0]             num,
    input  logic [W-1:0]             den,
    output spi_pkg::spi_div_status_t status,
    output logic [W-1:0]             quo,
    output logic [W-1:0]             rem
);

    localparam int CNT_W = $clog2(W + 1);

    logic [CNT_W-1:0] count_reg;
    logic             done_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     den_reg;

    logic [W:0]       rem_sh;
    logic [W:0]       diff;
    logic             ge;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[W-1]};
        diff   = rem_sh - {1'b0, den_reg};
        ge     = rem_sh >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (count_reg == CNT_W'(1)) && !start;
            if (start)
                count_reg <= CNT_W'(W);
            else if (count_reg != '0)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (count_reg != '0)
        begin
            rem_reg <= ge ? diff[W-1:0] : rem_sh[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign status.busy = count_reg != '0;
    assign status.done = done_reg;
    assign quo         = quo_reg;
    assign rem         = rem_reg;

endmodule

/* rtl/core/spi_fifo.sv */
// short command queue between the event front end and the point sequencer
// no package dependencies; depth of at least two
module spi_fifo #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* rtl/core/spi_front.sv */
// event front end: keeps the last point, computes deltas and distance, queues commands
// no package dependencies; command layout is shared with spi_back
module spi_front #(
    parameter int C = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_drag,
    input  logic [C-1:0]     in_x,
    input  logic [C-1:0]     in_y,
    output logic             push_valid,
    input  logic             push_ready,
    output logic [5*C+2:0]   push_data
);

    logic [C-1:0] prev_x_reg;
    logic [C-1:0] prev_y_reg;

    logic [C:0]   dx;
    logic [C:0]   dy;
    logic [C:0]   ax_w;
    logic [C:0]   ay_w;
    logic [C-1:0] ax;
    logic [C-1:0] ay;
    logic [C-1:0] n;
    logic [C-1:0] start_x;
    logic [C-1:0] start_y;
    logic         accept;

    always_comb
    begin
        dx      = {in_x[C-1], in_x} - {prev_x_reg[C-1], prev_x_reg};
        dy      = {in_y[C-1], in_y} - {prev_y_reg[C-1], prev_y_reg};
        ax_w    = dx[C] ? -dx : dx;
        ay_w    = dy[C] ? -dy : dy;
        ax      = ax_w[C-1:0];
        ay      = ay_w[C-1:0];
        n       = (ax >= ay) ? ax : ay;
        // a press starts and ends at its own point
        start_x = in_drag ? prev_x_reg : in_x;
        start_y = in_drag ? prev_y_reg : in_y;
    end

    // a drag with no movement is dropped here, nothing to emit
    assign in_ready   = push_ready;
    assign push_valid = in_valid && (!in_drag || (n != '0));
    assign push_data  = {in_drag, n, dy, dx, start_y, start_x};
    assign accept     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
        end
        else if (accept)
        begin
            prev_x_reg <= in_x;
            prev_y_reg <= in_y;
        end
    end

endmodule

/* rtl/core/spi_back.sv */
// point sequencer: stride and step division on the shared divider, then one point a cycle
// when not stalled; depends on spi_pkg, spi_div; command layout shared with spi_front
module spi_back #(
    parameter int C = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  logic [5*C+2:0]                    cmd_data,
    input  logic [spi_pkg::STEPS_BITS-1:0]    step_cap,
    input  logic [spi_pkg::HEIGHT_BITS-1:0]   canvas_height,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [C-1:0]                      out_x,
    output logic [C:0]                        out_y,
    output logic                              out_last
);

    localparam int DW = 2 * C;
    localparam int YW = (C + 2 > spi_pkg::HEIGHT_BITS + 1) ? C + 2 : spi_pkg::HEIGHT_BITS + 1;
    localparam int SB = spi_pkg::STEPS_BITS;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV_S = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_DIV_X = 6'b001000,
        ST_DIV_Y = 6'b010000,
        ST_EMIT  = 6'b100000
    } spi_state_t;

    spi_state_t state_reg, state_next;

    logic                 out_valid_reg, out_valid_next;
    logic [C-1:0]         out_x_reg, out_x_next;
    logic [C:0]           out_y_reg, out_y_next;
    logic                 out_last_reg, out_last_next;

    logic [C-1:0]         n_reg, n_next;
    logic [C-1:0]         ax_reg, ax_next;
    logic [C-1:0]         ay_reg, ay_next;
    logic                 dx_neg_reg, dx_neg_next;
    logic                 dy_neg_reg, dy_neg_next;
    logic [C-1:0]         stride_reg, stride_next;
    logic [DW-1:0]        prod_x_reg, prod_x_next;
    logic [DW-1:0]        prod_y_reg, prod_y_next;
    logic signed [C+1:0]  qx_reg, qx_next;
    logic signed [C+1:0]  qy_reg, qy_next;
    logic [C-1:0]         rx_reg, rx_next;
    logic [C-1:0]         ry_reg, ry_next;
    logic signed [C+1:0]  qsx_reg, qsx_next;
    logic signed [C+1:0]  qsy_reg, qsy_next;
    logic [C-1:0]         rsx_reg, rsx_next;
    logic [C-1:0]         rsy_reg, rsy_next;
    logic [C:0]           i_reg, i_next;

    logic                     div_start;
    logic [DW-1:0]            div_num;
    logic [DW-1:0]            div_den;
    spi_pkg::spi_div_status_t div_status;
    logic [DW-1:0]            div_quo;
    logic [DW-1:0]            div_rem;

    logic [C-1:0]         cmd_x;
    logic [C-1:0]         cmd_y;
    logic [C:0]           cmd_dx;
    logic [C:0]           cmd_dy;
    logic [C-1:0]         cmd_n;
    logic                 cmd_drag;
    logic [C:0]           cmd_ax_w;
    logic [C:0]           cmd_ay_w;
    logic [SB-1:0]        ms_clamp;
    logic [C-1:0]         stride_c;

    logic signed [C+1:0]  tx;
    logic signed [C+1:0]  ty;
    logic signed [YW-1:0] fy;
    logic [C+1:0]         reach;
    logic                 last_c;
    logic [C:0]           rsum_x;
    logic [C:0]           rsum_y;
    logic [C:0]           rdiff_x;
    logic [C:0]           rdiff_y;
    logic                 wrap_x;
    logic                 wrap_y;
    logic                 load_out;

    // floor-divided step: quotient and a remainder kept in [0, n)
    function automatic logic [2*C+1:0] floor_step(input logic neg, input logic [DW-1:0] quo,
                                                  input logic [DW-1:0] rem,
                                                  input logic [C-1:0] n);
        logic signed [C+1:0] qmag;
        logic signed [C+1:0] q;
        logic [C-1:0]        r;
        qmag = signed'({2'b00, quo[C-1:0]});
        if (!neg)
        begin
            q = qmag;
            r = rem[C-1:0];
        end
        else if (rem[C-1:0] == '0)
        begin
            q = -qmag;
            r = '0;
        end
        else
        begin
            q = -qmag - (C+2)'(1);
            r = n - rem[C-1:0];
        end
        return {q, r};
    endfunction

    spi_div #(
        .W (DW)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .status (div_status),
        .quo    (div_quo),
        .rem    (div_rem)
    );

    always_comb
    begin
        cmd_x    = cmd_data[C-1:0];
        cmd_y    = cmd_data[2*C-1:C];
        cmd_dx   = cmd_data[3*C:2*C];
        cmd_dy   = cmd_data[4*C+1:3*C+1];
        cmd_n    = cmd_data[5*C+1:4*C+2];
        cmd_drag = cmd_data[5*C+2];
        cmd_ax_w = cmd_dx[C] ? -cmd_dx : cmd_dx;
        cmd_ay_w = cmd_dy[C] ? -cmd_dy : cmd_dy;

        if (step_cap == '0)
            ms_clamp = SB'(1);
        else if (step_cap > SB'(spi_pkg::STEPS_LIMIT))
            ms_clamp = SB'(spi_pkg::STEPS_LIMIT);
        else
            ms_clamp = step_cap;

        // quotient zero means n below the cap
        stride_c = (div_quo == '0) ? C'(1) : div_quo[C-1:0];

        // truncate toward zero from the floor form
        tx = (qx_reg[C+1] && (rx_reg != '0)) ? qx_reg + (C+2)'(1) : qx_reg;
        ty = (qy_reg[C+1] && (ry_reg != '0)) ? qy_reg + (C+2)'(1) : qy_reg;
        fy = signed'(YW'(canvas_height)) - YW'(ty);

        reach  = {1'b0, i_reg} + {2'b00, stride_reg};
        last_c = reach >= {2'b00, n_reg};

        rsum_x  = {1'b0, rx_reg} + {1'b0, rsx_reg};
        rsum_y  = {1'b0, ry_reg} + {1'b0, rsy_reg};
        rdiff_x = rsum_x - {1'b0, n_reg};
        rdiff_y = rsum_y - {1'b0, n_reg};
        wrap_x  = rsum_x >= {1'b0, n_reg};
        wrap_y  = rsum_y >= {1'b0, n_reg};

        load_out = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;
        n_next         = n_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        dx_neg_next    = dx_neg_reg;
        dy_neg_next    = dy_neg_reg;
        stride_next    = stride_reg;
        prod_x_next    = prod_x_reg;
        prod_y_next    = prod_y_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        qsx_next       = qsx_reg;
        qsy_next       = qsy_reg;
        rsx_next       = rsx_reg;
        rsy_next       = rsy_reg;
        i_next         = i_reg;
        cmd_ready      = 1'b0;
        div_start      = 1'b0;
        div_num        = prod_x_reg;
        div_den        = DW'(n_reg);

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    qx_next     = signed'({{2{cmd_x[C-1]}}, cmd_x});
                    qy_next     = signed'({{2{cmd_y[C-1]}}, cmd_y});
                    rx_next     = '0;
                    ry_next     = '0;
                    i_next      = '0;
                    ax_next     = cmd_ax_w[C-1:0];
                    ay_next     = cmd_ay_w[C-1:0];
                    dx_neg_next = cmd_dx[C];
                    dy_neg_next = cmd_dy[C];
                    if (cmd_drag)
                    begin
                        n_next     = cmd_n;
                        div_start  = 1'b1;
                        div_num    = DW'(cmd_n);
                        div_den    = DW'(ms_clamp);
                        state_next = ST_DIV_S;
                    end
                    else
                    begin
                        // a press is a one-point run
                        n_next      = C'(1);
                        stride_next = C'(1);
                        state_next  = ST_EMIT;
                    end
                end
            end
            ST_DIV_S:
            begin
                if (div_status.done)
                begin
                    stride_next = stride_c;
                    prod_x_next = {{C{1'b0}}, stride_c} * {{C{1'b0}}, ax_reg};
                    prod_y_next = {{C{1'b0}}, stride_c} * {{C{1'b0}}, ay_reg};
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                div_start  = 1'b1;
                div_num    = prod_x_reg;
                state_next = ST_DIV_X;
            end
            ST_DIV_X:
            begin
                if (div_status.done)
                begin
                    {qsx_next, rsx_next} = floor_step(dx_neg_reg, div_quo, div_rem, n_reg);
                    div_start  = 1'b1;
                    div_num    = prod_y_reg;
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y:
            begin
                if (div_status.done)
                begin
                    {qsy_next, rsy_next} = floor_step(dy_neg_reg, div_quo, div_rem, n_reg);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = tx[C-1:0];
                    out_y_next     = fy[C:0];
                    out_last_next  = last_c;
                    i_next         = reach[C:0];
                    qx_next        = qx_reg + qsx_reg + (wrap_x ? (C+2)'(1) : (C+2)'(0));
                    qy_next        = qy_reg + qsy_reg + (wrap_y ? (C+2)'(1) : (C+2)'(0));
                    rx_next        = wrap_x ? rdiff_x[C-1:0] : rsum_x[C-1:0];
                    ry_next        = wrap_y ? rdiff_y[C-1:0] : rsum_y[C-1:0];
                    if (last_c)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
        n_reg        <= n_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        dx_neg_reg   <= dx_neg_next;
        dy_neg_reg   <= dy_neg_next;
        stride_reg   <= stride_next;
        prod_x_reg   <= prod_x_next;
        prod_y_reg   <= prod_y_next;
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        qsx_reg      <= qsx_next;
        qsy_reg      <= qsy_next;
        rsx_reg      <= rsx_next;
        rsy_reg      <= rsy_next;
        i_reg        <= i_next;
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_last  = out_last_reg;

endmodule

/* rtl/core/stroke_point_interpolator.sv */
// top level of the stroke point interpolator: config registers, front end, queue, sequencer
// depends on spi_pkg, spi_front, spi_fifo, spi_back (and spi_div below it)
//
//  channel   direction  handshake           payload
//  s_*       in         s_tvalid/s_tready   s_tdata {pos_y, pos_x}, s_tuser mode
//  m_*       out        m_tvalid/m_tready   m_tdata {stamp_y, stamp_x}, m_tlast last_of_run
//  cfg_*     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// a press passes through the queue and the sequencer to the output register; a drag
// first runs three divisions on the shared divider (stride, x step, y step), then it
// emits ceil(n/stride) points, one per cycle while m_tready does not hold the output;
// a drag with no movement emits nothing
// the queue of QUEUE_DEPTH commands lets events enter while the sequencer works or the
// output stalls; m_tready low holds the output register and the emitting sequencer
// reset clears the last point to zero and loads the register defaults; no clearing pass
module stroke_point_interpolator #(
    parameter int COORD_BITS  = spi_pkg::COORD_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = spi_pkg::QUEUE_DEPTH_DEFAULT,
    localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + 1 + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [IN_W-1:0]                    s_tdata,   // pos_x, pos_y, zero pad
    input  logic                               s_tuser,   // mode
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [OUT_W-1:0]                   m_tdata,   // stamp_x, stamp_y, zero pad
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [spi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [spi_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int C     = COORD_BITS;
    localparam int CMD_W = 5 * C + 3;

    logic [spi_pkg::STEPS_BITS-1:0]  step_cap_reg;
    logic [spi_pkg::HEIGHT_BITS-1:0] canvas_height_reg;

    logic             push_valid;
    logic             push_ready;
    logic [CMD_W-1:0] push_data;
    logic             pop_valid;
    logic             pop_ready;
    logic [CMD_W-1:0] pop_data;
    logic [C-1:0]     out_x;
    logic [C:0]       out_y;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cap_reg      <= spi_pkg::STEPS_BITS'(spi_pkg::STEPS_RESET);
            canvas_height_reg <= spi_pkg::HEIGHT_BITS'(spi_pkg::HEIGHT_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                spi_pkg::CFG_MAX_STEPS:
                    step_cap_reg <= cfg_data[spi_pkg::STEPS_BITS-1:0];
                spi_pkg::CFG_CANVAS_HEIGHT:
                    canvas_height_reg <= cfg_data[spi_pkg::HEIGHT_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    spi_front #(
        .C (C)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_drag    (s_tuser),
        .in_x       (s_tdata[C-1:0]),
        .in_y       (s_tdata[2*C-1:C]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    spi_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    spi_back #(
        .C (C)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (pop_valid),
        .cmd_ready     (pop_ready),
        .cmd_data      (pop_data),
        .step_cap      (step_cap_reg),
        .canvas_height (canvas_height_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_last      (m_tlast)
    );

    assign m_tdata = OUT_W'({out_y, out_x});

endmodule

/* dv/testbench.sv */
// self-checking testbench for stroke_point_interpolator: pointer events in, stamp points out
// depends on spi_pkg and the rtl under rtl/core; predicts every stamp from its own stroke model
`timescale 1ns / 1ps

module testbench;

    localparam int COORD_BITS = spi_pkg::COORD_BITS_DEFAULT;
    localparam int IN_W       = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W      = ((2 * COORD_BITS + 1 + 7) / 8) * 8;
    localparam int SETTLE     = 400;      // quiet cycles between phases
    localparam int LONG_HOLD  = 600;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES     = 6;
    localparam int PHASE_ITEMS = 78;

    typedef enum bit {PRESS_EVENT = 1'b0, DRAG_EVENT = 1'b1} event_kind_t;

    typedef struct {
        event_kind_t                   kind;
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
    } pointer_event_t;

    typedef struct {
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS:0]    y;
        logic                          last;
    } stamp_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [IN_W-1:0]                    s_tdata = '0;   // pos_x, pos_y, zero pad
    logic                               s_tuser = 1'b0; // mode
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [OUT_W-1:0]                   m_tdata;        // stamp_x, stamp_y, zero pad
    logic                               m_tlast;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [spi_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [spi_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

    stroke_point_interpolator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // stroke model state
    logic signed [COORD_BITS-1:0]          last_x = '0;
    logic signed [COORD_BITS-1:0]          last_y = '0;
    logic [spi_pkg::STEPS_BITS-1:0]        steps_cfg = spi_pkg::STEPS_RESET;
    logic [spi_pkg::HEIGHT_BITS-1:0]       height_cfg = spi_pkg::HEIGHT_RESET;

    pointer_event_t pending_events[$];
    stamp_t         stamps_due[$];
    pointer_event_t offered_event;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int holds_started = 0;
    int stall_left = 0;
    int cycle_count = 0;
    int errors = 0;
    int events_sent = 0;
    int presses_sent = 0;
    int drags_sent = 0;
    int stamps_checked = 0;
    int cfg_writes = 0;

    function automatic void emit_stamp(longint px, longint py, bit last);
        stamp_t s;
        longint fy;
        fy = longint'(height_cfg) - py;
        s.x = px[COORD_BITS-1:0];
        s.y = fy[COORD_BITS:0];
        s.last = last;
        stamps_due = {stamps_due, s};
    endfunction

    // stamps caused by one event; updates the last point
    function automatic void trace_stroke(pointer_event_t ev);
        longint dx, dy, ax, ay, span, cap, stride, i, px, py;
        if (ev.kind == PRESS_EVENT)
        begin
            emit_stamp(longint'(ev.x), longint'(ev.y), 1'b1);
        end
        else
        begin
            dx = longint'(ev.x) - longint'(last_x);
            dy = longint'(ev.y) - longint'(last_y);
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            span = ax > ay ? ax : ay;
            cap = longint'(steps_cfg);
            if (cap < 1)
                cap = 1;
            if (cap > spi_pkg::STEPS_LIMIT)
                cap = spi_pkg::STEPS_LIMIT;
            stride = span > cap ? span / cap : 1;
            for (i = 0; i < span; i += stride)
            begin
                px = (longint'(last_x) * span + i * dx) / span;
                py = (longint'(last_y) * span + i * dy) / span;
                emit_stamp(px, py, i + stride >= span);
            end
        end
        last_x = ev.x;
        last_y = ev.y;
    endfunction

    // sender: holds the offered event until its transfer, then maybe idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                trace_stroke(offered_event);
                events_sent++;
                if (offered_event.kind == PRESS_EVENT)
                    presses_sent++;
                else
                    drags_sent++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered_event = pending_events.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {offered_event.y, offered_event.x};
                    s_tuser  <= offered_event.kind;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (holds_started != hold_requests)
            begin
                holds_started++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= $urandom_range(99) >= recv_stall_pct;
            end
        end
    end

    // checker
    always @(posedge clk)
    begin
        stamp_t want;
        logic signed [COORD_BITS-1:0] got_x;
        logic signed [COORD_BITS:0]   got_y;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_x = m_tdata[COORD_BITS-1:0];
            got_y = m_tdata[2*COORD_BITS:COORD_BITS];
            if (stamps_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected stamp x=%0d y=%0d last=%0b",
                         $time, got_x, got_y, m_tlast);
            end
            else
            begin
                want = stamps_due.pop_front();
                stamps_checked++;
                if (got_x !== want.x || got_y !== want.y || m_tlast !== want.last)
                begin
                    errors++;
                    $display("%0t: stamp mismatch: expected x=%0d y=%0d last=%0b, %s",
                             $time, want.x, want.y, want.last, "actual");
                    $display("%0t:   actual x=%0d y=%0d last=%0b",
                             $time, got_x, got_y, m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d events pending, %0d stamps due",
                     $time, pending_events.size(), stamps_due.size());
            $display("testbench failed");
            $finish;
        end
    end

    task automatic add_event(event_kind_t kind, int x, int y);
        pointer_event_t ev;
        ev.kind = kind;
        ev.x = x[COORD_BITS-1:0];
        ev.y = y[COORD_BITS-1:0];
        pending_events = {pending_events, ev};
    endtask

    // well-formed strokes (press then drags) with some noise events between them
    task automatic queue_strokes(int count);
        int reach, len, nx, ny, cx, cy;
        while (count > 0)
        begin
            if ($urandom_range(7) == 0)
            begin
                add_event(event_kind_t'($urandom_range(1)), $urandom, $urandom);
                count--;
            end
            else
            begin
                case ($urandom_range(9))
                    0, 1:    reach = 0;
                    2, 3, 4: reach = 8;
                    5, 6:    reach = 40;
                    7, 8:    reach = 400;
                    default: reach = 4095;
                endcase
                cx = $urandom_range(4095) - 2048;
                cy = $urandom_range(4095) - 2048;
                add_event(PRESS_EVENT, cx, cy);
                count--;
                len = $urandom_range(1, 8);
                while (len > 0 && count > 0)
                begin
                    nx = cx + int'($urandom_range(2 * reach)) - reach;
                    ny = cy + int'($urandom_range(2 * reach)) - reach;
                    cx = nx < -2048 ? -2048 : (nx > 2047 ? 2047 : nx);
                    cy = ny < -2048 ? -2048 : (ny > 2047 ? 2047 : ny);
                    add_event(DRAG_EVENT, cx, cy);
                    count--;
                    len--;
                end
            end
        end
    endtask

    // waits until every queued event has been taken and every stamp has come back, then settles
    task automatic drain(int settle);
        do
            @(posedge clk);
        while (pending_events.size() != 0 || s_tvalid || stamps_due.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(logic [spi_pkg::CFG_INDEX_BITS-1:0] index,
                             logic [spi_pkg::CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        if (index == spi_pkg::CFG_MAX_STEPS)
            steps_cfg = value[spi_pkg::STEPS_BITS-1:0];
        else if (index == spi_pkg::CFG_CANVAS_HEIGHT)
            height_cfg = value[spi_pkg::HEIGHT_BITS-1:0];
    endtask

    initial
    begin
        int steps_plan[PHASES];
        int height_plan[PHASES];
        steps_plan  = '{30, 0, 63, 1, 32, 17};
        height_plan = '{480, 2047, 0, 1, 1023, 600};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, zero-length drags, stride edges around the step cap
        add_event(PRESS_EVENT, 0, 0);
        add_event(DRAG_EVENT, 0, 0);
        add_event(DRAG_EVENT, 1, 0);
        add_event(DRAG_EVENT, -2, 3);
        add_event(DRAG_EVENT, 2047, -2048);
        add_event(DRAG_EVENT, -2048, 2047);
        add_event(PRESS_EVENT, 2047, 2047);
        add_event(DRAG_EVENT, 2047, 2047);
        add_event(DRAG_EVENT, 2017, 2030);
        add_event(DRAG_EVENT, 1986, 2030);
        add_event(DRAG_EVENT, 1926, 2000);
        add_event(DRAG_EVENT, 1867, 1941);
        add_event(PRESS_EVENT, -5, -7);
        add_event(DRAG_EVENT, 2, -20);
        add_event(DRAG_EVENT, -2048, -2048);
        add_event(DRAG_EVENT, 2047, 2047);
        add_event(PRESS_EVENT, -1, -1);
        add_event(DRAG_EVENT, 0, 0);
        add_event(PRESS_EVENT, -2048, 2047);
        add_event(DRAG_EVENT, -2047, 2040);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                drain(SETTLE);
                write_reg(spi_pkg::CFG_MAX_STEPS,
                          spi_pkg::CFG_DATA_BITS'(steps_plan[p]));
                write_reg(spi_pkg::CFG_CANVAS_HEIGHT,
                          spi_pkg::CFG_DATA_BITS'(height_plan[p]));
            end
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            if (p == 1)
            begin
                // sender pauses mid-phase until the block has emptied
                queue_strokes(PHASE_ITEMS / 2);
                drain(0);
                queue_strokes(PHASE_ITEMS - PHASE_ITEMS / 2);
            end
            else
            begin
                queue_strokes(PHASE_ITEMS);
                if (p == 4)
                    hold_requests++;   // output held off while input keeps coming
            end
        end

        drain(SETTLE);
        $display("covered %0d events (%0d presses, %0d drags), %0d stamps checked",
                 events_sent, presses_sent, drags_sent, stamps_checked);
        $display("%0d register writes over %0d settings, with idle, stall and hold-off phases",
                 cfg_writes, PHASES);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
